>>> rtl/dcf_ftd_pkg.sv
`timescale 1ns / 1ps
// Package: field positions, limits and shared types of the time-code frame decoder.
package dcf_ftd_pkg;

    localparam int unsigned FRAME_W   = 59;
    localparam int unsigned HOURS_W   = 6;
    localparam int unsigned MINUTES_W = 7;
    localparam int unsigned PREV_H_W  = 5;
    localparam int unsigned PREV_M_W  = 6;

    // Bit positions inside the frame
    localparam int unsigned START_POS   = 0;
    localparam int unsigned MARKER_POS  = 20;
    localparam int unsigned MIN_POS     = 21;
    localparam int unsigned MIN_PAR_POS = 28;
    localparam int unsigned HR_POS      = 29;
    localparam int unsigned HR_PAR_POS  = 35;

    // Plausibility limits and wrap points
    localparam logic [HOURS_W-1:0]   HOURS_LIMIT   = 6'd24;
    localparam logic [MINUTES_W-1:0] MINUTES_LIMIT = 7'd60;
    localparam logic [PREV_M_W-1:0]  LAST_MINUTE   = 6'd59;
    localparam logic [PREV_H_W-1:0]  LAST_HOUR     = 5'd23;

    typedef struct packed {
        logic                 frame_ok;
        logic                 plausible;
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
    } dcf_ftd_dec_t;

endpackage

>>> rtl/dcf77_frame_time_decoder_core.sv
`timescale 1ns / 1ps
// Top level: time-code frame decoder with input register and result register.
//
// Usage
//   Input channel (s_valid/s_ready/s_raw_frame): one 59-bit received frame
//   per beat, second 0 in bit 0.
//   Result channel (m_valid/m_ready/m_*): one result beat per input beat, in
//   order: frame_ok, time_plausible, set_clock, decoded_hours/minutes.
//   Path: an accepted frame goes into the input register, then through the
//   decode/compare logic into the result register, which drives m_valid.
//   Throughput: one beat per cycle while m_ready stays high; the result
//   register holds while its beat is not taken.
//   Stall: when m_ready is low the result register holds, the input
//   register fills, and s_ready drops only once both stages are occupied.
//   The last plausible time is updated as a frame moves from the input
//   register into the result register, so frames are compared in order.
//   Reset (aresetn low, synchronous): both stages empty, last time 00:00.
//   The first frame after reset raises set_clock only if its minutes read 01; its hours are not checked.
module dcf77_frame_time_decoder_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dcf_ftd_pkg::FRAME_W-1:0]     s_raw_frame,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_frame_ok,
    output logic                                m_time_plausible,
    output logic                                m_set_clock,
    output logic [dcf_ftd_pkg::HOURS_W-1:0]     m_decoded_hours,
    output logic [dcf_ftd_pkg::MINUTES_W-1:0]   m_decoded_minutes
);
    import dcf_ftd_pkg::*;

    // Input stage
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [FRAME_W-1:0] frame_reg;

    // Result stage
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 ok_reg;
    logic                 plaus_reg;
    logic                 setc_reg;
    logic [HOURS_W-1:0]   hours_reg;
    logic [MINUTES_W-1:0] minutes_reg;

    dcf_ftd_dec_t dec;
    logic         set_clock;
    logic         advance;   // input stage moves into result stage
    logic         out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (out_free) begin
            out_valid_next = in_valid_reg;
        end
    end

    dcf_ftd_decode u_decode (
        .frame (frame_reg),
        .dec   (dec)
    );

    dcf_ftd_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update    (advance),
        .dec       (dec),
        .set_clock (set_clock)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            frame_reg <= s_raw_frame;
        end
        if (advance) begin
            ok_reg      <= dec.frame_ok;
            plaus_reg   <= dec.plausible;
            setc_reg    <= set_clock;
            hours_reg   <= dec.hours;
            minutes_reg <= dec.minutes;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_frame_ok        = ok_reg;
    assign m_time_plausible  = plaus_reg;
    assign m_set_clock       = setc_reg;
    assign m_decoded_hours   = hours_reg;
    assign m_decoded_minutes = minutes_reg;

endmodule

>>> rtl/dcf_ftd_decode.sv
`timescale 1ns / 1ps
// Frame check and BCD decode of one registered time-code frame.
module dcf_ftd_decode (
    input  logic [dcf_ftd_pkg::FRAME_W-1:0] frame,
    output dcf_ftd_pkg::dcf_ftd_dec_t        dec
);
    import dcf_ftd_pkg::*;

    logic [3:0]           min_units;
    logic [2:0]           min_tens;
    logic [3:0]           hr_units;
    logic [1:0]           hr_tens;
    logic [MINUTES_W-1:0] minutes;
    logic [HOURS_W-1:0]   hours;
    logic                 ok;

    assign min_units = frame[MIN_POS +: 4];
    assign min_tens  = frame[MIN_POS+4 +: 3];
    assign hr_units  = frame[HR_POS +: 4];
    assign hr_tens   = frame[HR_POS+4 +: 2];

    // tens * 10 = tens*8 + tens*2
    assign minutes = {1'b0, min_tens, 3'b000} + {3'b000, min_tens, 1'b0} + {3'b000, min_units};
    assign hours   = {1'b0, hr_tens, 3'b000} + {3'b000, hr_tens, 1'b0} + {2'b00, hr_units};

    // Start bit low, marker high, even parity over each field plus its parity bit
    assign ok = !frame[START_POS] && frame[MARKER_POS]
             && !(^frame[MIN_PAR_POS:MIN_POS])
             && !(^frame[HR_PAR_POS:HR_POS]);

    assign dec.frame_ok  = ok;
    assign dec.plausible = ok && (hours < HOURS_LIMIT) && (minutes < MINUTES_LIMIT);
    assign dec.hours     = hours;
    assign dec.minutes   = minutes;

endmodule

>>> rtl/dcf_ftd_track.sv
`timescale 1ns / 1ps
// Last plausible time register and consecutive-minute check.
module dcf_ftd_track (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      update,
    input  dcf_ftd_pkg::dcf_ftd_dec_t dec,
    output logic                      set_clock
);
    import dcf_ftd_pkg::*;

    logic [PREV_H_W-1:0]  prev_hours_reg;
    logic [PREV_M_W-1:0]  prev_minutes_reg;
    logic [PREV_H_W-1:0]  prev_hours_next;
    logic [PREV_M_W-1:0]  prev_minutes_next;
    logic [MINUTES_W-1:0] min_expect;
    logic [HOURS_W-1:0]   hr_expect;
    logic                 consec;

    assign min_expect = {1'b0, prev_minutes_reg} + 7'd1;
    assign hr_expect  = (prev_hours_reg < LAST_HOUR) ? ({1'b0, prev_hours_reg} + 6'd1) : 6'd0;

    always_comb begin
        if (prev_minutes_reg < LAST_MINUTE) begin
            consec = (dec.minutes == min_expect);
        end else begin
            consec = (dec.minutes == '0) && (dec.hours == hr_expect);
        end
    end

    assign set_clock = dec.plausible && consec;

    always_comb begin
        prev_hours_next   = prev_hours_reg;
        prev_minutes_next = prev_minutes_reg;
        if (update && dec.plausible) begin
            prev_hours_next   = dec.hours[PREV_H_W-1:0];
            prev_minutes_next = dec.minutes[PREV_M_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_hours_reg   <= '0;
            prev_minutes_reg <= '0;
        end else begin
            prev_hours_reg   <= prev_hours_next;
            prev_minutes_reg <= prev_minutes_next;
        end
    end

endmodule

>>> rtl/dcf_ftd_checker.sv
`timescale 1ns / 1ps
// Port checker for the time-code frame decoder, bound to the top level.
module dcf_ftd_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [dcf_ftd_pkg::FRAME_W-1:0]     s_raw_frame,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_frame_ok,
    input  logic                                m_time_plausible,
    input  logic                                m_set_clock,
    input  logic [dcf_ftd_pkg::HOURS_W-1:0]     m_decoded_hours,
    input  logic [dcf_ftd_pkg::MINUTES_W-1:0]   m_decoded_minutes
);
    import dcf_ftd_pkg::*;

    // Waiting input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_raw_frame))
        else $error("input beat changed while waiting");

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_ok)
            && $stable(m_time_plausible) && $stable(m_set_clock)
            && $stable(m_decoded_hours) && $stable(m_decoded_minutes))
        else $error("result beat changed while stalled");

    a_plaus_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_time_plausible |-> m_frame_ok)
        else $error("plausible without frame_ok");

    a_setc_plaus: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_set_clock |-> m_time_plausible)
        else $error("set_clock without plausible time");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_time_plausible |->
            (m_decoded_hours < HOURS_LIMIT) && (m_decoded_minutes < MINUTES_LIMIT))
        else $error("plausible time out of range");

endmodule

bind dcf77_frame_time_decoder_core dcf_ftd_checker u_dcf_ftd_checker (.*);
